// ===== design/itpq_pkg.sv =====
package itpq_pkg;

   // Fixed widths of the channel fields.
   localparam int OP_BITS      = 2;
   localparam int TASK_BITS    = 8;
   localparam int USER_ID_BITS = 16;
   localparam int PRIO_IN_BITS = 16;
   localparam int STATUS_BITS  = 2;

   // Defaults for the top level parameters.
   localparam int TASK_ID_COUNT_DEF = 256;
   localparam int USER_BITS_DEF     = 16;
   localparam int PRIORITY_BITS_DEF = 16;

   typedef logic [OP_BITS-1:0]     op_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   localparam op_type OP_ADD  = 2'd0;
   localparam op_type OP_EDIT = 2'd1;
   localparam op_type OP_REM  = 2'd2;
   localparam op_type OP_EXEC = 2'd3;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_ABSENT   = 2'd1;
   localparam status_type ST_EMPTY    = 2'd2;
   localparam status_type ST_REPLACED = 2'd3;

   // Control from the sequencer to the best-entry tracker.
   typedef struct packed {
      logic clear;
      logic sample;
   } best_ctrl_type;

endpackage

// ===== design/indexed_task_priority_queue_unit.sv =====
// Indexed task priority table with one entry per task id.
// Input channel (req_*): one operation per transaction: add, edit priority,
// remove, or execute top. Result channel (rsp_*): exactly one transaction per
// input transaction, in order, carrying top_user, top_task and status.
// Both channels use valid/ready; a transaction moves when both are high.
// Add, edit and remove read their entry in the lookup state and then load the
// result into the output register once it is free. Execute top scans every
// entry through the single read port of the table memory, one entry per cycle,
// and then removes the best entry, if any, in the finish state. One operation is
// in flight at a time; req_ready rises together with rsp_valid, so a new request
// is accepted only after the result of the last one has been loaded.
// Reset: after reset the block runs a clearing pass over the table memory
// that lasts TASK_ID_COUNT cycles, with req_ready low, and then starts empty.
// Stall: the result is held in an output register. If the receiver stalls,
// the next input transaction can still be accepted and processed; it waits
// in its final state until the output register is free.
module indexed_task_priority_queue_unit
   import itpq_pkg::*;
#(
   parameter int TASK_ID_COUNT = TASK_ID_COUNT_DEF,
   parameter int USER_BITS     = USER_BITS_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OP_BITS-1:0]      req_operation,
   input  logic [TASK_BITS-1:0]    req_task_id,
   input  logic [USER_ID_BITS-1:0] req_user_id,
   input  logic [PRIO_IN_BITS-1:0] req_priority_req,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [USER_ID_BITS-1:0] rsp_top_user,
   output logic [TASK_BITS-1:0]    rsp_top_task,
   output logic [STATUS_BITS-1:0]  rsp_status
);

   localparam int ID_BITS    = (TASK_ID_COUNT > 1) ? $clog2(TASK_ID_COUNT) : 1;
   localparam int WORD_BITS  = 1 + USER_BITS + PRIORITY_BITS;
   localparam logic [ID_BITS-1:0] LAST_ID = ID_BITS'(TASK_ID_COUNT - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOOKUP = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [ID_BITS-1:0]       scan_idx_ff, scan_idx_in;
   op_type                   op_ff;
   logic [ID_BITS-1:0]       id_ff;
   logic                     in_range_ff;
   logic [USER_BITS-1:0]     user_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [USER_ID_BITS-1:0] rsp_user_ff, rsp_user_in;
   logic [TASK_BITS-1:0]    rsp_task_ff, rsp_task_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                 mem_wr_en;
   logic [ID_BITS-1:0]   mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [ID_BITS-1:0]   mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;

   logic                     rd_valid;
   logic [USER_BITS-1:0]     rd_user;
   logic [PRIORITY_BITS-1:0] rd_prio;

   best_ctrl_type            best_ctrl;
   logic                     best_found;
   logic [ID_BITS-1:0]       best_id;
   logic [USER_BITS-1:0]     best_user;
   logic [PRIORITY_BITS-1:0] best_prio;

   logic accept;
   logic slot_free;

   assign rd_valid = mem_rd_data[WORD_BITS-1];
   assign rd_user  = mem_rd_data[WORD_BITS-2 -: USER_BITS];
   assign rd_prio  = mem_rd_data[PRIORITY_BITS-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   itpq_mem #(
      .DEPTH     (TASK_ID_COUNT),
      .WIDTH     (WORD_BITS),
      .ADDR_BITS (ID_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   itpq_best #(
      .ID_BITS       (ID_BITS),
      .USER_BITS     (USER_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_best (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (best_ctrl),
      .entry_id    (scan_idx_ff),
      .entry_valid (rd_valid),
      .entry_user  (rd_user),
      .entry_prio  (rd_prio),
      .best_found  (best_found),
      .best_id     (best_id),
      .best_user   (best_user),
      .best_prio   (best_prio)
   );

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = id_ff;
      mem_wr_data   = {1'b1, user_ff, prio_ff};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = ID_BITS'(32'(req_task_id));
      best_ctrl     = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_user_in   = rsp_user_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = scan_idx_ff;
            mem_wr_data = '0;
            scan_idx_in = scan_idx_ff + ID_BITS'(1);
            if (scan_idx_ff == LAST_ID) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               mem_rd_en = 1'b1;
               if (req_operation == OP_EXEC) begin
                  mem_rd_addr     = '0;
                  scan_idx_in     = '0;
                  best_ctrl.clear = 1'b1;
                  state_in        = S_SCAN;
               end else begin
                  state_in = S_LOOKUP;
               end
            end
         end
         S_LOOKUP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = '0;
               rsp_task_in  = '0;
               state_in     = S_IDLE;
               if (!in_range_ff) begin
                  rsp_status_in = ST_ABSENT;
               end else begin
                  case (op_ff)
                     OP_ADD: begin
                        mem_wr_en     = 1'b1;
                        mem_wr_data   = {1'b1, user_ff, prio_ff};
                        rsp_status_in = rd_valid ? ST_REPLACED : ST_OK;
                     end
                     OP_EDIT: begin
                        mem_wr_en     = rd_valid;
                        mem_wr_data   = {1'b1, rd_user, prio_ff};
                        rsp_status_in = rd_valid ? ST_OK : ST_ABSENT;
                     end
                     default: begin
                        mem_wr_en     = rd_valid;
                        mem_wr_data   = {1'b0, rd_user, rd_prio};
                        rsp_status_in = rd_valid ? ST_OK : ST_ABSENT;
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            // Read data belongs to the entry addressed in the previous cycle.
            best_ctrl.sample = 1'b1;
            if (scan_idx_ff == LAST_ID) begin
               state_in = S_FINISH;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = scan_idx_ff + ID_BITS'(1);
               scan_idx_in = scan_idx_ff + ID_BITS'(1);
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (best_found) begin
                  mem_wr_en     = 1'b1;
                  mem_wr_addr   = best_id;
                  mem_wr_data   = {1'b0, best_user, best_prio};
                  rsp_user_in   = USER_ID_BITS'(best_user);
                  rsp_task_in   = TASK_BITS'(best_id);
                  rsp_status_in = ST_OK;
               end else begin
                  rsp_user_in   = '0;
                  rsp_task_in   = '0;
                  rsp_status_in = ST_EMPTY;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_user_ff   <= rsp_user_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         op_ff       <= req_operation;
         id_ff       <= ID_BITS'(32'(req_task_id));
         in_range_ff <= (32'(req_task_id) < 32'(TASK_ID_COUNT));
         user_ff     <= USER_BITS'(req_user_id);
         prio_ff     <= PRIORITY_BITS'(req_priority_req);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_top_user = rsp_user_ff;
   assign rsp_top_task = rsp_task_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef SYNTH
   // A new result is only loaded at the end of a lookup or a scan.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_LOOKUP || $past(state_ff) == S_FINISH))
      else $error("result loaded outside a finishing state");

   // An empty-table result carries no task.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_EMPTY |-> rsp_task_ff == '0 && rsp_user_ff == '0)
      else $error("empty result carries a task");

   // Execute top always removes the chosen entry.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && mem_wr_en |-> !mem_wr_data[WORD_BITS-1] && mem_wr_addr == best_id)
      else $error("execute top writes a valid entry");

   // A scan ends with exactly one sample of the last entry.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && scan_idx_ff == LAST_ID |=> state_ff == S_FINISH)
      else $error("scan did not stop at the last entry");
`endif

endmodule

// ===== design/itpq_mem.sv =====
module itpq_mem #(
   parameter int DEPTH     = 256,
   parameter int WIDTH     = 33,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/itpq_best.sv =====
module itpq_best
   import itpq_pkg::*;
#(
   parameter int ID_BITS       = 8,
   parameter int USER_BITS     = 16,
   parameter int PRIORITY_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  best_ctrl_type            ctrl,
   input  logic [ID_BITS-1:0]       entry_id,
   input  logic                     entry_valid,
   input  logic [USER_BITS-1:0]     entry_user,
   input  logic [PRIORITY_BITS-1:0] entry_prio,
   output logic                     best_found,
   output logic [ID_BITS-1:0]       best_id,
   output logic [USER_BITS-1:0]     best_user,
   output logic [PRIORITY_BITS-1:0] best_prio
);

   logic                     found_ff;
   logic [ID_BITS-1:0]       id_ff;
   logic [USER_BITS-1:0]     user_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic                     take;

   // Entries arrive in ascending id order, so >= keeps the highest id on a tie.
   assign take = ctrl.sample && entry_valid && (!found_ff || entry_prio >= prio_ff);

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         id_ff   <= entry_id;
         user_ff <= entry_user;
         prio_ff <= entry_prio;
      end
   end

   assign best_found = found_ff;
   assign best_id    = id_ff;
   assign best_user  = user_ff;
   assign best_prio  = prio_ff;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import itpq_pkg::*;

   localparam int TABLE_DEPTH    = TASK_ID_COUNT_DEF;
   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 1400;
   localparam int QUIET_ITEMS    = 150;
   localparam int HOLD_AT_ITEM   = 150;
   localparam int HOLD_CYCLES    = 700;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int TAIL_CYCLES    = 300;
   localparam int TIMEOUT_CYCLES = 2000000;
   localparam int MAX_REPORTED   = 10;

   typedef struct packed {
      logic [USER_ID_BITS-1:0] top_user;
      logic [TASK_BITS-1:0]    top_task;
      status_type              status;
   } outcome_type;

   class task_table_scoreboard;
      bit                      occupied [TABLE_DEPTH];
      logic [USER_ID_BITS-1:0] owner    [TABLE_DEPTH];
      logic [PRIO_IN_BITS-1:0] rank     [TABLE_DEPTH];
      outcome_type             pending_outcomes [$];
      int                      failures;
      int                      checked;
      int                      op_seen [4];
      int                      status_seen [4];

      // Updates the shadow table for one accepted operation and queues the
      // outcome the block must return for it.
      function void apply_operation(op_type op, logic [TASK_BITS-1:0] id,
                                    logic [USER_ID_BITS-1:0] user,
                                    logic [PRIO_IN_BITS-1:0] prio);
         outcome_type res;
         bit          found;
         int          best;
         int          i;
         res   = '0;
         found = 1'b0;
         best  = 0;
         case (op)
            OP_ADD: begin
               if (occupied[id]) res.status = ST_REPLACED;
               occupied[id] = 1'b1;
               owner[id]    = user;
               rank[id]     = prio;
            end
            OP_EDIT: begin
               if (occupied[id]) rank[id] = prio;
               else res.status = ST_ABSENT;
            end
            OP_REM: begin
               if (occupied[id]) occupied[id] = 1'b0;
               else res.status = ST_ABSENT;
            end
            default: begin
               // Ascending scan with >= so the highest id wins a priority tie.
               for (i = 0; i < TABLE_DEPTH; i++) begin
                  if (occupied[i] && (!found || rank[i] >= rank[best])) begin
                     found = 1'b1;
                     best  = i;
                  end
               end
               if (found) begin
                  occupied[best] = 1'b0;
                  res.top_user   = owner[best];
                  res.top_task   = best[TASK_BITS-1:0];
               end else begin
                  res.status = ST_EMPTY;
               end
            end
         endcase
         op_seen[op]++;
         status_seen[res.status]++;
         pending_outcomes.push_back(res);
      endfunction

      function void check_response(logic [USER_ID_BITS-1:0] user,
                                   logic [TASK_BITS-1:0] id, status_type status);
         outcome_type want;
         if (pending_outcomes.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTED)
               $display("Unexpected result: user %h task %h status %0d", user, id, status);
            return;
         end
         want = pending_outcomes.pop_front();
         checked++;
         if (user !== want.top_user || id !== want.top_task || status !== want.status) begin
            failures++;
            if (failures <= MAX_REPORTED)
               $display("Result %0d: expected %h/%h/%0d, got %h/%h/%0d (user/task/status)",
                        checked, want.top_user, want.top_task, want.status, user, id, status);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OP_BITS-1:0]      req_operation = OP_ADD;
   logic [TASK_BITS-1:0]    req_task_id = '0;
   logic [USER_ID_BITS-1:0] req_user_id = '0;
   logic [PRIO_IN_BITS-1:0] req_priority_req = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [USER_ID_BITS-1:0] rsp_top_user;
   logic [TASK_BITS-1:0]    rsp_top_task;
   logic [STATUS_BITS-1:0]  rsp_status;

   task_table_scoreboard sb = new;
   int  sent_count = 0;
   bit  quiet = 1'b0;

   indexed_task_priority_queue_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_task_id      (req_task_id),
      .req_user_id      (req_user_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_top_user     (rsp_top_user),
      .rsp_top_task     (rsp_top_task),
      .rsp_status       (rsp_status)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("FAILED: results differ");
      $finish;
   end

   // Results are checked before the same edge's request is noted, since a
   // result can never belong to a transaction accepted at that edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_top_user, rsp_top_task, rsp_status);
         if (req_valid && req_ready)
            sb.apply_operation(req_operation, req_task_id, req_user_id, req_priority_req);
      end
   end

   task automatic send_item(input op_type op, input logic [TASK_BITS-1:0] id,
                            input logic [USER_ID_BITS-1:0] user,
                            input logic [PRIO_IN_BITS-1:0] prio);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_task_id      <= id;
      req_user_id      <= user;
      req_priority_req <= prio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // The receiver stalls in short random bursts, and once for a long stretch
   // so that the block fills up and holds off its input.
   initial begin : receiver
      int  held;
      bit  hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!hold_done && sent_count >= HOLD_AT_ITEM) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int                      n;
      int                      pick;
      int                      id_base;
      int                      waited;
      op_type                  op;
      logic [TASK_BITS-1:0]    id;
      logic [USER_ID_BITS-1:0] user;
      logic [PRIO_IN_BITS-1:0] prio;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Empty table, absent ids, extreme fields, replace and priority ties.
      send_item(OP_EXEC, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_EDIT, 8'h05, 16'h0000, 16'h1234);
      send_item(OP_REM,  8'h00, 16'hFFFF, 16'h0000);
      send_item(OP_ADD,  8'h00, 16'h0000, 16'h0000);
      send_item(OP_ADD,  8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_ADD,  8'h80, 16'h1234, 16'hFFFF);
      send_item(OP_ADD,  8'h80, 16'h5555, 16'hFFFF);
      send_item(OP_EXEC, 8'h00, 16'h0000, 16'h0000);
      send_item(OP_EXEC, 8'hA5, 16'h5A5A, 16'hA5A5);
      send_item(OP_ADD,  8'h07, 16'hAAAA, 16'h0000);
      send_item(OP_EDIT, 8'h00, 16'h1111, 16'h8000);
      send_item(OP_EXEC, 8'h00, 16'h0000, 16'h0000);
      send_item(OP_REM,  8'h07, 16'h0000, 16'h0000);
      send_item(OP_REM,  8'h07, 16'h0000, 16'h0000);
      send_item(OP_EXEC, 8'h00, 16'h0000, 16'h0000);
      send_item(OP_ADD,  8'h01, 16'h0001, 16'h0001);
      send_item(OP_ADD,  8'h02, 16'h0002, 16'h0001);
      send_item(OP_EDIT, 8'h01, 16'h0000, 16'h0002);
      send_item(OP_EXEC, 8'h00, 16'h0000, 16'h0000);
      send_item(OP_EXEC, 8'h00, 16'h0000, 16'h0000);
      send_item(OP_EXEC, 8'h00, 16'h0000, 16'h0000);

      // Most ids come from a narrow moving window, so edits and removes
      // usually find a present task and adds often replace one.
      id_base = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) id_base = $urandom_range(0, 240);
         if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 35) op = OP_ADD;
         else if (pick < 55) op = OP_EDIT;
         else if (pick < 70) op = OP_REM;
         else op = OP_EXEC;
         if ($urandom_range(0, 9) < 7) id = TASK_BITS'(id_base + $urandom_range(0, 15));
         else id = TASK_BITS'($urandom_range(0, 255));
         user = USER_ID_BITS'($urandom_range(0, 65535));
         if ($urandom_range(0, 1) == 1) prio = PRIO_IN_BITS'($urandom_range(0, 3));
         else prio = PRIO_IN_BITS'($urandom_range(0, 65535));
         send_item(op, id, user, prio);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (sb.pending_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending_outcomes.size() != 0) begin
         $display("%0d expected results never arrived", sb.pending_outcomes.size());
         sb.failures += sb.pending_outcomes.size();
      end

      $display("Sent %0d transactions: %0d add, %0d edit, %0d remove, %0d execute top.",
               sent_count, sb.op_seen[OP_ADD], sb.op_seen[OP_EDIT], sb.op_seen[OP_REM],
               sb.op_seen[OP_EXEC]);
      $display("Outcomes: %0d ok, %0d absent, %0d empty, %0d replaced; %0d results checked.",
               sb.status_seen[ST_OK], sb.status_seen[ST_ABSENT], sb.status_seen[ST_EMPTY],
               sb.status_seen[ST_REPLACED], sb.checked);
      if (sb.failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
